// ===== hdl/otapt_pkg.sv =====
// ----------------------------------------------------------------------------
// otapt_pkg
// shared types, codes and defaults for the outdoor temperature averager and
// party timer block
// ----------------------------------------------------------------------------
`default_nettype none

package otapt_pkg;

    // default parameter values
    localparam int MINUTE_WINDOW_DEF   = 60;
    localparam int MAX_LONG_WINDOW_DEF = 64;
    localparam int TEMP_WIDTH_DEF      = 12;

    // fixed field widths
    localparam int PARTY_W    = 10;
    localparam int WIN_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // register reset values
    localparam logic [PARTY_W-1:0] PARTY_RESET  = PARTY_W'(120);
    localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(36);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PARTY_MINUTES = 1'b0,
        CFG_LONG_WINDOW   = 1'b1
    } t_cfg_idx;

    // one party timer channel
    typedef struct packed {
        logic               prev;
        logic               flag;
        logic [PARTY_W-1:0] left;
    } t_party;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SWEEP,
        ST_M_RD,
        ST_M_UPD,
        ST_M_DIV,
        ST_M_WAIT,
        ST_H_RD,
        ST_H_UPD,
        ST_H_DIV,
        ST_H_WAIT,
        ST_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic cap;
        logic sweep;
        logic sweep_clr;
        logic init_load;
        logic m_rd;
        logic m_upd;
        logic h_rd;
        logic h_upd;
        logic div_start;
        logic div_sel_hour;
        logic m_avg_ld;
        logic h_avg_ld;
        logic out_ld;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic kind;
        logic mtick;
        logic htick;
        logic sweep_last;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/otapt_div.sv =====
// ----------------------------------------------------------------------------
// otapt_div
// iterative restoring divider, signed dividend by unsigned divisor, one
// quotient bit per cycle, quotient truncated toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module otapt_div #(
    parameter int DIV_W = 19,
    parameter int DVS_W = 7
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [DIV_W-1:0] i_dividend,
    input  wire logic        [DVS_W-1:0] i_divisor,
    output logic                         o_done,
    output logic signed      [DIV_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DIV_W-1];
            r_quo <= i_dividend[DIV_W-1] ? DIV_W'(-i_dividend) : DIV_W'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? signed'(-r_quo) : signed'(r_quo);

endmodule

`default_nettype wire

// ===== hdl/otapt_datapath.sv =====
// ----------------------------------------------------------------------------
// otapt_datapath
// party timers, minute and hour rings with running sums, shared divider,
// configuration registers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module otapt_datapath #(
    parameter int MINUTE_WINDOW   = otapt_pkg::MINUTE_WINDOW_DEF,
    parameter int MAX_LONG_WINDOW = otapt_pkg::MAX_LONG_WINDOW_DEF,
    parameter int TEMP_WIDTH      = otapt_pkg::TEMP_WIDTH_DEF,
    parameter int IN_W            = 16,
    parameter int OUT_W           = 48
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire otapt_pkg::t_cmd                     i_cmd,
    output otapt_pkg::t_status                       o_status,
    input  wire logic [IN_W-1:0]                     i_in_data,
    input  wire logic                                i_in_kind,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [OUT_W-1:0]                         o_out_data,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [otapt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [otapt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int TW      = TEMP_WIDTH;
    localparam int MW      = MINUTE_WINDOW;
    localparam int LW      = MAX_LONG_WINDOW;
    localparam int PW      = otapt_pkg::PARTY_W;
    localparam int MPOS_W  = $clog2(MW);
    localparam int HPOS_W  = $clog2(LW);
    localparam int NW      = $clog2(LW + 1);
    localparam int MSUM_W  = TW + $clog2(MW);
    localparam int LSUM_W  = TW + $clog2(LW) + 1;
    localparam int DIV_W   = (MSUM_W > LSUM_W) ? MSUM_W : LSUM_W;
    localparam int DVS_MAX = (MW > LW) ? MW : LW;
    localparam int DVS_W   = $clog2(DVS_MAX + 1);
    localparam int SWEEP_N = DVS_MAX;
    localparam int SW_W    = $clog2(SWEEP_N);

    localparam logic signed [DIV_W-1:0] T_HI = DIV_W'(2**(TW-1) - 1);
    localparam logic signed [DIV_W-1:0] T_LO = -T_HI - DIV_W'(1);

    // configuration
    logic [PW-1:0]                       r_party_minutes;
    logic [otapt_pkg::WIN_W-1:0]         r_long_window;

    // latched item
    logic signed [TW-1:0] r_temp;
    logic                 r_kind;
    logic                 r_mtick;
    logic                 r_htick;

    // timers
    otapt_pkg::t_party r_heat;
    otapt_pkg::t_party r_water;

    // averaging state
    logic signed [MSUM_W-1:0] r_msum;
    logic signed [LSUM_W-1:0] r_lsum;
    logic [MPOS_W-1:0]        r_mpos;
    logic [HPOS_W-1:0]        r_hpos;
    logic signed [TW-1:0]     r_havg;
    logic signed [TW-1:0]     r_lavg;
    logic [SW_W-1:0]          r_swp;

    // rings
    logic signed [TW-1:0] r_mring [MW];
    logic signed [TW-1:0] r_hring [LW];
    logic signed [TW-1:0] r_m_rdata;
    logic signed [TW-1:0] r_h_rdata;

    // result register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    logic [NW-1:0]            n_win;
    logic [HPOS_W-1:0]        hp_eff;
    logic [31:0]              hp_inc;
    logic                     m_we;
    logic [MPOS_W-1:0]        m_wa;
    logic signed [TW-1:0]     m_wd;
    logic                     h_we;
    logic [HPOS_W-1:0]        h_wa;
    logic signed [TW-1:0]     h_wd;
    logic [31:0]              h_limit;
    logic signed [DIV_W-1:0]  div_num;
    logic [DVS_W-1:0]         div_dvs;
    logic                     div_done;
    logic signed [DIV_W-1:0]  div_q;
    logic signed [TW-1:0]     q_sat;
    logic signed [TW-1:0]     in_temp;
    logic                     in_heat;
    logic                     in_water;
    logic                     in_mtick;
    logic                     in_htick;

    function automatic otapt_pkg::t_party party_step(
        otapt_pkg::t_party cur,
        logic              sw,
        logic              tick,
        logic [PW-1:0]     load
    );
        otapt_pkg::t_party nx;
        nx = cur;
        if (sw && !cur.prev) begin
            nx.flag = 1'b1;
            nx.left = load;
        end
        nx.prev = sw;
        if (tick) begin
            if (nx.left != '0) begin
                nx.left = nx.left - 1'b1;
            end else begin
                nx.flag = 1'b0;
            end
            if (!sw) begin
                nx.flag = 1'b0;
            end
        end
        return nx;
    endfunction

    // input fields, lowest bit up: heat switch, water switch, temp, minute, hour
    assign in_heat  = i_in_data[0];
    assign in_water = i_in_data[1];
    assign in_temp  = signed'(i_in_data[TW+1:2]);
    assign in_mtick = i_in_data[TW+2];
    assign in_htick = i_in_data[TW+3];

    // effective long window, clamped to 1..LW
    always_comb begin
        if (r_long_window == '0) begin
            n_win = NW'(1);
        end else if (32'(r_long_window) > LW) begin
            n_win = NW'(LW);
        end else begin
            n_win = NW'(r_long_window);
        end
    end

    // hour position restarts when the window shrank below it
    assign hp_eff = (32'(r_hpos) >= 32'(n_win)) ? '0 : r_hpos;
    assign hp_inc = 32'(hp_eff) + 32'd1;

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_party_minutes <= otapt_pkg::PARTY_RESET;
            r_long_window   <= otapt_pkg::WINDOW_RESET;
        end else if (i_cfg_valid) begin
            unique case (otapt_pkg::t_cfg_idx'(i_cfg_index))
                otapt_pkg::CFG_PARTY_MINUTES: r_party_minutes <= i_cfg_data[PW-1:0];
                otapt_pkg::CFG_LONG_WINDOW:   r_long_window   <= i_cfg_data[otapt_pkg::WIN_W-1:0];
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_temp  <= in_temp;
            r_kind  <= i_in_kind;
            r_mtick <= in_mtick;
            r_htick <= in_htick;
        end
    end

    // timers, sums, positions, means
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat  <= '0;
            r_water <= '0;
            r_msum  <= '0;
            r_lsum  <= '0;
            r_mpos  <= '0;
            r_hpos  <= '0;
            r_havg  <= '0;
            r_lavg  <= '0;
            r_swp   <= '0;
        end else begin
            if (i_cmd.cap && !i_in_kind) begin
                r_heat  <= party_step(r_heat, in_heat, in_mtick, r_party_minutes);
                r_water <= party_step(r_water, in_water, in_mtick, r_party_minutes);
            end
            if (i_cmd.sweep) begin
                r_swp <= (32'(r_swp) == SWEEP_N - 1) ? '0 : r_swp + 1'b1;
            end
            if (i_cmd.init_load) begin
                r_msum <= MSUM_W'(MSUM_W'(r_temp) * MSUM_W'(MW));
                r_lsum <= LSUM_W'(LSUM_W'(r_temp) * LSUM_W'(n_win));
                r_havg <= r_temp;
                r_lavg <= r_temp;
            end
            if (i_cmd.m_upd) begin
                r_msum <= r_msum + MSUM_W'(r_temp) - MSUM_W'(r_m_rdata);
                r_mpos <= (32'(r_mpos) == MW - 1) ? '0 : r_mpos + 1'b1;
            end
            if (i_cmd.h_upd) begin
                r_lsum <= r_lsum + LSUM_W'(r_havg) - LSUM_W'(r_h_rdata);
                r_hpos <= (hp_inc >= 32'(n_win)) ? '0 : HPOS_W'(hp_inc);
            end
            if (i_cmd.m_avg_ld) begin
                r_havg <= q_sat;
            end
            if (i_cmd.h_avg_ld) begin
                r_lavg <= q_sat;
            end
        end
    end

    // ring write selection: sweep, or the normal replace of the oldest entry
    assign h_limit = i_cmd.sweep_clr ? 32'(LW) : 32'(n_win);

    always_comb begin
        m_we = 1'b0;
        m_wa = r_mpos;
        m_wd = r_temp;
        h_we = 1'b0;
        h_wa = hp_eff;
        h_wd = r_havg;
        if (i_cmd.sweep) begin
            m_we = (32'(r_swp) < MW);
            m_wa = r_swp[MPOS_W-1:0];
            m_wd = i_cmd.sweep_clr ? '0 : r_temp;
            h_we = (32'(r_swp) < h_limit);
            h_wa = r_swp[HPOS_W-1:0];
            h_wd = i_cmd.sweep_clr ? '0 : r_temp;
        end else begin
            m_we = i_cmd.m_upd;
            h_we = i_cmd.h_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mring[m_wa] <= m_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.m_rd) begin
            r_m_rdata <= r_mring[r_mpos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_hring[h_wa] <= h_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.h_rd) begin
            r_h_rdata <= r_hring[hp_eff];
        end
    end

    // shared divider for both means
    assign div_num = i_cmd.div_sel_hour ? DIV_W'(r_lsum) : DIV_W'(r_msum);
    assign div_dvs = i_cmd.div_sel_hour ? DVS_W'(n_win) : DVS_W'(MW);

    otapt_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        if (div_q > T_HI) begin
            q_sat = T_HI[TW-1:0];
        end else if (div_q < T_LO) begin
            q_sat = T_LO[TW-1:0];
        end else begin
            q_sat = div_q[TW-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_data <= OUT_W'({r_lavg, r_havg, r_water.left, r_heat.left,
                                  r_water.flag, r_heat.flag});
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_status.kind       = r_kind;
    assign o_status.mtick      = r_mtick;
    assign o_status.htick      = r_htick;
    assign o_status.sweep_last = (32'(r_swp) == SWEEP_N - 1);
    assign o_status.div_done   = div_done;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ===== hdl/otapt_ctrl.sv =====
// ----------------------------------------------------------------------------
// otapt_ctrl
// sequencer: clearing pass, item capture, ring sweep, minute and hour
// updates through the shared divider, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module otapt_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire otapt_pkg::t_status  i_status,
    output otapt_pkg::t_cmd          o_cmd
);

    otapt_pkg::t_state r_state;
    otapt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= otapt_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == otapt_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            otapt_pkg::ST_CLEAR: begin
                o_cmd.sweep     = 1'b1;
                o_cmd.sweep_clr = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = otapt_pkg::ST_IDLE;
                end
            end
            otapt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = otapt_pkg::ST_DECODE;
                end
            end
            otapt_pkg::ST_DECODE: begin
                if (i_status.kind) begin
                    n_state = otapt_pkg::ST_SWEEP;
                end else if (i_status.mtick) begin
                    n_state = otapt_pkg::ST_M_RD;
                end else if (i_status.htick) begin
                    n_state = otapt_pkg::ST_H_RD;
                end else begin
                    n_state = otapt_pkg::ST_FIN;
                end
            end
            otapt_pkg::ST_SWEEP: begin
                o_cmd.sweep     = 1'b1;
                o_cmd.init_load = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = otapt_pkg::ST_FIN;
                end
            end
            otapt_pkg::ST_M_RD: begin
                o_cmd.m_rd = 1'b1;
                n_state    = otapt_pkg::ST_M_UPD;
            end
            otapt_pkg::ST_M_UPD: begin
                o_cmd.m_upd = 1'b1;
                n_state     = otapt_pkg::ST_M_DIV;
            end
            otapt_pkg::ST_M_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = otapt_pkg::ST_M_WAIT;
            end
            otapt_pkg::ST_M_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.m_avg_ld = 1'b1;
                    n_state = i_status.htick ? otapt_pkg::ST_H_RD : otapt_pkg::ST_FIN;
                end
            end
            otapt_pkg::ST_H_RD: begin
                o_cmd.h_rd = 1'b1;
                n_state    = otapt_pkg::ST_H_UPD;
            end
            otapt_pkg::ST_H_UPD: begin
                o_cmd.h_upd = 1'b1;
                n_state     = otapt_pkg::ST_H_DIV;
            end
            otapt_pkg::ST_H_DIV: begin
                o_cmd.div_start    = 1'b1;
                o_cmd.div_sel_hour = 1'b1;
                n_state            = otapt_pkg::ST_H_WAIT;
            end
            otapt_pkg::ST_H_WAIT: begin
                o_cmd.div_sel_hour = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.h_avg_ld = 1'b1;
                    n_state        = otapt_pkg::ST_FIN;
                end
            end
            otapt_pkg::ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = otapt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = otapt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/outdoor_temp_average_and_party_timer.sv =====
// ----------------------------------------------------------------------------
// outdoor_temp_average_and_party_timer
// hourly and long outdoor temperature means with heating and hot water
// party override timers
// ----------------------------------------------------------------------------
// One item is one scheduler call and gives exactly one result item. Items are
// worked one at a time. Each minute or hour strobe goes through a registered
// read of its ring and the shared one-bit-per-cycle divider that forms both
// means; DIV_W is the running-sum width, 19 bits at the default sizes. An init
// item rewrites both rings one entry a cycle. After reset the block runs a
// clearing pass over both rings and takes no item until it is done;
// configuration writes are taken at any time and should only be made while
// the block is idle. A finished result waits in an output register, and the
// next item is accepted while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module outdoor_temp_average_and_party_timer #(
    parameter int MINUTE_WINDOW   = otapt_pkg::MINUTE_WINDOW_DEF,
    parameter int MAX_LONG_WINDOW = otapt_pkg::MAX_LONG_WINDOW_DEF,
    parameter int TEMP_WIDTH      = otapt_pkg::TEMP_WIDTH_DEF,
    localparam int IN_W  = ((TEMP_WIDTH + 4 + 7) / 8) * 8,
    localparam int OUT_W = ((2 + 2 * otapt_pkg::PARTY_W + 2 * TEMP_WIDTH + 7) / 8) * 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // heat_party_switch, water_party_switch, outdoor_temp, minute_tick, hour_tick
    input  wire logic [IN_W-1:0]                  i_s_axis_tdata,
    // kind
    input  wire logic                             i_s_axis_tuser,
    // result stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // heat_party_active, water_party_active, heat_minutes_left,
    // water_minutes_left, hour_mean, long_mean
    output logic [OUT_W-1:0]                      o_m_axis_tdata,
    // configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [otapt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [otapt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    otapt_pkg::t_cmd    cmd;
    otapt_pkg::t_status status;

    // sequencer
    otapt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // timers, rings, sums, divider and result register
    otapt_datapath #(
        .MINUTE_WINDOW   (MINUTE_WINDOW),
        .MAX_LONG_WINDOW (MAX_LONG_WINDOW),
        .TEMP_WIDTH      (TEMP_WIDTH),
        .IN_W            (IN_W),
        .OUT_W           (OUT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_s_axis_tdata),
        .i_in_kind   (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // an accepted item takes the sequencer out of idle at once
    a_busy_after_accept : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready
    ) else $error("input still ready right after an accepted item");

    // a result is only loaded when the output register is free
    a_no_overwrite : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_ld |-> (!o_m_axis_tvalid || i_m_axis_tready)
    ) else $error("pending result overwritten");

    // a result appears only after the sequencer loaded one
    a_valid_from_load : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(cmd.out_ld)
    ) else $error("result valid without a load");

endmodule

`default_nettype wire

// ===== dv/otapt_result_checker.sv =====
// ----------------------------------------------------------------------------
// otapt_result_checker
// watches the call, result and register channels of the temperature averager
// and party timer, keeps its own copy of the rings, sums and timers, and
// compares every result item field by field with the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module otapt_result_checker
    import otapt_pkg::*;
#(
    parameter int IN_W  = 16,
    parameter int OUT_W = 48
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_call_valid,
    input  wire logic                  i_call_ready,
    input  wire logic [IN_W-1:0]       i_call_data,
    input  wire logic                  i_call_kind,
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_ready,
    input  wire logic [OUT_W-1:0]      i_res_data,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_failures,
    output int                         o_outstanding
);

    localparam int MINUTES   = MINUTE_WINDOW_DEF;
    localparam int HOURS_MAX = MAX_LONG_WINDOW_DEF;
    localparam int TW        = TEMP_WIDTH_DEF;
    localparam int HEAT      = 0;
    localparam int WATER     = 1;
    localparam int PRINT_CAP = 60;

    typedef struct packed {
        logic                 heat_on;
        logic                 water_on;
        logic [PARTY_W-1:0]   heat_left;
        logic [PARTY_W-1:0]   water_left;
        logic signed [TW-1:0] hour_mean;
        logic signed [TW-1:0] long_mean;
    } reading_t;

    reading_t due_readings[$];

    // averaging state
    int minute_ring[MINUTES];
    int hour_ring[HOURS_MAX];
    int minute_sum;
    int long_sum;
    int minute_pos;
    int hour_pos;
    int hour_avg;
    int long_avg;

    // party timers, heating then hot water
    logic sw_prev[2];
    logic party_on[2];
    int   party_left[2];

    // register copies
    int party_len;
    int window_raw;

    initial begin
        o_failures    = 0;
        o_outstanding = 0;
    end

    function automatic int clamp_temp(input int v);
        int hi;
        hi = 2 ** (TW - 1) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic int window_now();
        int n;
        n = window_raw;
        if (n < 1) n = 1;
        if (n > HOURS_MAX) n = HOURS_MAX;
        return n;
    endfunction

    task automatic clear_model();
        foreach (minute_ring[i]) minute_ring[i] = 0;
        foreach (hour_ring[i]) hour_ring[i] = 0;
        minute_sum = 0;
        long_sum   = 0;
        minute_pos = 0;
        hour_pos   = 0;
        hour_avg   = 0;
        long_avg   = 0;
        for (int c = 0; c < 2; c++) begin
            sw_prev[c]    = 1'b0;
            party_on[c]   = 1'b0;
            party_left[c] = 0;
        end
        party_len  = int'(PARTY_RESET);
        window_raw = int'(WINDOW_RESET);
    endtask

    function automatic reading_t advance_call(input logic kind, input logic [IN_W-1:0] d);
        logic                 sw[2];
        logic signed [TW-1:0] t_raw;
        int                   t;
        int                   n;
        reading_t             r;
        sw[HEAT]  = d[0];
        sw[WATER] = d[1];
        t_raw     = d[2 +: TW];
        t         = t_raw;
        n         = window_now();
        if (kind) begin
            // preload both rings, positions and timers untouched
            foreach (minute_ring[i]) minute_ring[i] = t;
            for (int i = 0; i < n; i++) hour_ring[i] = t;
            minute_sum = t * MINUTES;
            long_sum   = t * n;
            hour_avg   = t;
            long_avg   = t;
        end else begin
            for (int c = 0; c < 2; c++) begin
                if (sw[c] && !sw_prev[c]) begin
                    party_on[c]   = 1'b1;
                    party_left[c] = party_len;
                end
                sw_prev[c] = sw[c];
            end
            if (d[TW+2]) begin
                for (int c = 0; c < 2; c++) begin
                    if (party_left[c] > 0) party_left[c]--;
                    else party_on[c] = 1'b0;
                    if (!sw[c]) party_on[c] = 1'b0;
                end
                if (minute_pos >= MINUTES) minute_pos = 0;
                minute_sum += t - minute_ring[minute_pos];
                minute_ring[minute_pos] = t;
                minute_pos++;
                if (minute_pos >= MINUTES) minute_pos = 0;
                hour_avg = clamp_temp(minute_sum / MINUTES);
            end
            // the hour update takes the hourly mean of this same call
            if (d[TW+3]) begin
                if (hour_pos >= n) hour_pos = 0;
                long_sum += hour_avg - hour_ring[hour_pos];
                hour_ring[hour_pos] = hour_avg;
                hour_pos++;
                if (hour_pos >= n) hour_pos = 0;
                long_avg = clamp_temp(long_sum / n);
            end
        end
        r.heat_on    = party_on[HEAT];
        r.water_on   = party_on[WATER];
        r.heat_left  = PARTY_W'(party_left[HEAT]);
        r.water_left = PARTY_W'(party_left[WATER]);
        r.hour_mean  = TW'(hour_avg);
        r.long_mean  = TW'(long_avg);
        return r;
    endfunction

    task automatic note_failure(input string what);
        o_failures++;
        if (o_failures <= PRINT_CAP)
            $display("[%0t] mismatch %0d: %s", $time, o_failures, what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            note_failure($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_reading(input logic [OUT_W-1:0] d);
        reading_t got;
        reading_t want;
        got.heat_on    = d[0];
        got.water_on   = d[1];
        got.heat_left  = d[2 +: PARTY_W];
        got.water_left = d[2+PARTY_W +: PARTY_W];
        got.hour_mean  = d[2+2*PARTY_W +: TW];
        got.long_mean  = d[2+2*PARTY_W+TW +: TW];
        if (due_readings.size() == 0) begin
            note_failure($sformatf("result item %h with nothing outstanding", d));
        end else begin
            want = due_readings.pop_front();
            check_field("heat_party_active", got.heat_on, want.heat_on);
            check_field("water_party_active", got.water_on, want.water_on);
            check_field("heat_minutes_left", got.heat_left, want.heat_left);
            check_field("water_minutes_left", got.water_left, want.water_left);
            check_field("hour_mean", got.hour_mean, want.hour_mean);
            check_field("long_mean", got.long_mean, want.long_mean);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
            due_readings.delete();
        end else begin
            if (i_res_valid && i_res_ready) check_reading(i_res_data);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PARTY_MINUTES) party_len = int'(i_cfg_data) & 'h3ff;
                else window_raw = int'(i_cfg_data) & 'h7f;
            end
            if (i_call_valid && i_call_ready)
                due_readings.push_back(advance_call(i_call_kind, i_call_data));
        end
        o_outstanding = due_readings.size();
    end

endmodule

`default_nettype wire

// ===== dv/outdoor_temp_average_and_party_timer_test.sv =====
// ----------------------------------------------------------------------------
// outdoor_temp_average_and_party_timer_test
// drives scheduler calls and register writes into the averager and party
// timer, with random gaps on the call side and random stalls on the result
// side; a checker module beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`default_nettype none

module outdoor_temp_average_and_party_timer_test;

    import otapt_pkg::*;

    localparam int TW            = TEMP_WIDTH_DEF;
    localparam int IN_W          = ((TW + 4 + 7) / 8) * 8;
    localparam int OUT_W         = ((2 + 2 * PARTY_W + 2 * TW + 7) / 8) * 8;
    localparam int TEMP_MAX      = 2 ** (TW - 1) - 1;
    localparam int TEMP_MIN      = -TEMP_MAX - 1;
    localparam int RANDOM_CALLS  = 1150;
    localparam int PHASES        = 10;
    // watchdog bound on the length of the whole run
    localparam int CYCLE_LIMIT   = 900000;
    // longer than an init item, the slowest thing the block does
    localparam int SETTLE_CYCLES = 120;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  call_valid = 1'b0;
    logic [IN_W-1:0]       call_data  = '0;
    logic                  call_kind  = 1'b0;
    logic                  call_ready;
    logic                  res_valid;
    logic                  res_ready  = 1'b0;
    logic [OUT_W-1:0]      res_data;
    logic                  cfg_valid  = 1'b0;
    t_cfg_idx              cfg_index  = CFG_PARTY_MINUTES;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  cfg_ready;

    int failures;
    int outstanding;
    int cycle_count = 0;
    // when set, neither side idles
    bit calm = 1'b0;

    // switch levels carried from one random call to the next
    logic heat_sw  = 1'b0;
    logic water_sw = 1'b0;

    outdoor_temp_average_and_party_timer u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (call_valid),
        .o_s_axis_tready (call_ready),
        .i_s_axis_tdata  (call_data),   // heat sw, water sw, temp, minute, hour
        .i_s_axis_tuser  (call_kind),   // kind
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),    // flags, timers, hour mean, long mean
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    otapt_result_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_call_valid  (call_valid),
        .i_call_ready  (call_ready),
        .i_call_data   (call_data),
        .i_call_kind   (call_kind),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_res_data    (res_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // watchdog on the whole run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("outdoor_temp_average_and_party_timer_test: errors");
            $finish;
        end
    end

    // idle length: mostly none, often short, now and then long
    function automatic int pick_idle();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure, runs for the whole test
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (calm) begin
                res_ready  <= 1'b1;
                stall_left = 0;
            end else if (stall_left > 0) begin
                res_ready  <= 1'b0;
                stall_left--;
            end else begin
                res_ready  <= 1'b1;
                stall_left = pick_idle();
            end
        end
    end

    // one scheduler call; valid stays high into the next call when no gap is drawn
    task automatic push_call(input logic kind, input logic hsw, input logic wsw,
                             input int temp, input logic mt, input logic ht);
        int              gap;
        logic [IN_W-1:0] d;
        gap          = pick_idle();
        d            = '0;
        d[0]         = hsw;
        d[1]         = wsw;
        d[2 +: TW]   = TW'(temp);
        d[TW+2]      = mt;
        d[TW+3]      = ht;
        if (gap > 0) begin
            call_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        call_valid <= 1'b1;
        call_data  <= d;
        call_kind  <= kind;
        do @(posedge clk); while (!call_ready);
    endtask

    // stop calling and wait until every predicted result has come back
    task automatic drain();
        call_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // both registers back to back, valid held high across the pair
    task automatic set_config(input int party, input int window);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PARTY_MINUTES;
        cfg_data  <= CFG_DATA_W'(party);
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_LONG_WINDOW;
        cfg_data  <= CFG_DATA_W'(window);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_party();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 1023;
        if (r == 2) return $urandom_range(0, 1023);
        return $urandom_range(1, 12);
    endfunction

    // out-of-range windows included: zero acts as one, above the ring acts as full
    function automatic int pick_window();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0) return 0;
        if (r == 1) return 127;
        if (r == 2) return MAX_LONG_WINDOW_DEF;
        if (r == 3) return 1;
        if (r == 4) return $urandom_range(MAX_LONG_WINDOW_DEF + 1, 127);
        if (r == 5) return $urandom_range(9, MAX_LONG_WINDOW_DEF - 1);
        return $urandom_range(2, 8);
    endfunction

    initial begin
        int per_phase;
        int base;
        int spread;
        int temp;
        int r;
        per_phase = RANDOM_CALLS / PHASES;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed: reset register values first ----
        push_call(1'b1, 1'b0, 1'b0, TEMP_MAX, 1'b0, 1'b0);  // init at hottest
        push_call(1'b0, 1'b1, 1'b0, TEMP_MIN, 1'b0, 1'b0);  // heating edge, no strobe
        push_call(1'b0, 1'b1, 1'b1, TEMP_MIN, 1'b1, 1'b0);  // water edge with minute
        push_call(1'b0, 1'b1, 1'b1, 0, 1'b0, 1'b1);         // hour strobe alone
        push_call(1'b0, 1'b1, 1'b1, TEMP_MAX, 1'b1, 1'b1);  // both strobes
        push_call(1'b0, 1'b0, 1'b1, -1, 1'b1, 1'b0);        // heating switched off
        drain();

        // zero load and a zero window
        set_config(0, 0);
        push_call(1'b0, 1'b1, 1'b1, 3, 1'b0, 1'b0);         // flag set, zero minutes
        push_call(1'b0, 1'b1, 1'b1, 100, 1'b1, 0);          // cleared at next minute
        push_call(1'b1, 1'b1, 1'b1, TEMP_MIN, 1'b0, 1'b0);  // init at coldest
        push_call(1'b0, 1'b1, 1'b1, TEMP_MAX, 1'b1, 1'b1);
        push_call(1'b0, 1'b0, 1'b0, 5, 1'b0, 1'b1);
        drain();

        // longest load and a window beyond the ring
        set_config(1023, 127);
        push_call(1'b0, 1'b0, 1'b1, -1, 1'b0, 1'b0);
        push_call(1'b0, 1'b1, 1'b1, -1, 1'b1, 1'b1);
        push_call(1'b1, 1'b1, 1'b1, -1, 1'b0, 1'b0);        // init, negative small
        push_call(1'b0, 1'b1, 1'b1, -1, 1'b1, 1'b1);
        push_call(1'b0, 1'b1, 1'b0, TEMP_MAX, 1'b1, 1'b1);  // water off on a minute
        drain();

        // shrink the window under the hour position so it restarts
        set_config(5, 1);
        push_call(1'b0, 1'b1, 1'b0, TEMP_MIN, 1'b1, 1'b1);
        push_call(1'b0, 1'b1, 1'b0, -7, 1'b0, 1'b1);
        push_call(1'b0, 1'b0, 1'b0, 7, 1'b1, 1'b0);
        drain();

        // full window, grown back over stale ring entries
        set_config(2, MAX_LONG_WINDOW_DEF);
        push_call(1'b0, 1'b1, 1'b1, TEMP_MAX, 1'b1, 1'b1);
        push_call(1'b0, 1'b1, 1'b1, TEMP_MIN, 1'b1, 1'b1);
        heat_sw  = 1'b1;
        water_sw = 1'b1;
        drain();

        // ---- random phases ----
        for (int ph = 0; ph < PHASES; ph++) begin
            set_config(pick_party(), pick_window());
            calm = (ph % 4 == 1);
            // each phase hovers around its own temperature
            base = int'($urandom_range(0, 4095)) - 2048;
            r    = $urandom_range(0, 2);
            spread = (r == 0) ? 3 : (r == 1) ? 64 : 2048;
            for (int k = 0; k < per_phase; k++) begin
                if ($urandom_range(0, 9) == 0) heat_sw  = ~heat_sw;
                if ($urandom_range(0, 9) == 0) water_sw = ~water_sw;
                temp = base + int'($urandom_range(0, 2 * spread)) - spread;
                if (temp > TEMP_MAX) temp = TEMP_MAX;
                if (temp < TEMP_MIN) temp = TEMP_MIN;
                push_call($urandom_range(0, 49) == 0, heat_sw, water_sw, temp,
                          $urandom_range(0, 2) != 0, $urandom_range(0, 5) == 0);
            end
            drain();
            calm = 1'b0;
        end

        // let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0) begin
            $display("outdoor_temp_average_and_party_timer_test: clean");
        end else begin
            $display("outdoor_temp_average_and_party_timer_test: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/otapt_pkg.sv
hdl/otapt_div.sv
hdl/otapt_datapath.sv
hdl/otapt_ctrl.sv
hdl/outdoor_temp_average_and_party_timer.sv
dv/otapt_result_checker.sv
dv/outdoor_temp_average_and_party_timer_test.sv
